// File: src/rlepd_pkg.sv
// Shared types and constants for the radar run-length packet decoder.
package rlepd_pkg;

    localparam logic [15:0] CODE_RADIAL   = 16'hAF1F;
    localparam logic [15:0] CODE_RASTER_A = 16'hBA0F;
    localparam logic [15:0] CODE_RASTER_B = 16'hBA07;

    localparam logic [3:0] RADIAL_HDR_LEN   = 4'd7;
    localparam logic [3:0] RADIAL_COUNT_POS = 4'd6;
    localparam logic [3:0] RASTER_HDR_LEN   = 4'd11;
    localparam logic [3:0] RASTER_COUNT_POS = 4'd9;

    // floor(x/10) = (x * 0xCCCD) >> 19 for any 16-bit x
    localparam logic [15:0] RECIP_TEN       = 16'hCCCD;
    localparam int          RECIP_TEN_SHIFT = 19;
    // floor(q/360) = (q * 5826) >> 21 for q below 6554
    localparam logic [12:0] RECIP_CIRCLE       = 13'd5826;
    localparam int          RECIP_CIRCLE_SHIFT = 21;
    localparam logic [12:0] FULL_CIRCLE        = 13'd360;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_HDR  = 4'b0010,
        ST_LHDR = 4'b0100,
        ST_DATA = 4'b1000
    } t_front_state;

    // One run halfword, bytes already in expansion order.
    typedef struct packed {
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [15:0] line_index;
        logic        is_raster;
        logic        first;
        logic        done;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

endpackage

// File: src/rlepd_front.sv
// Front end: packet, header and line parsing; queues run halfwords.
module rlepd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // [15:0] word
    input  logic                  i_q_full,
    output rlepd_pkg::t_push      o_push
);
    import rlepd_pkg::*;

    t_front_state r_state, n_state;
    logic [3:0]   r_hpos, n_hpos;
    logic [15:0]  r_lines, n_lines;
    logic [15:0]  r_words, n_words;
    logic [15:0]  r_cur, n_cur;
    logic         r_raster, n_raster;
    logic         r_started, n_started;
    logic         r_low_byte_first;
    logic [1:0]   r_ang_cnt, n_ang_cnt;
    logic [12:0]  r_quot;
    logic [4:0]   r_div;

    logic         w_accept;
    logic         w_finish;
    logic [15:0]  w_lines_dec;
    logic [15:0]  w_words_dec;
    logic [16:0]  w_bytes_inc;
    logic [15:0]  w_half;
    logic [31:0]  w_quot_prod;
    logic [25:0]  w_div_prod;
    logic [12:0]  w_rem;
    logic [7:0]   w_byte0;
    logic [7:0]   w_byte1;
    logic         w_any_span;

    assign s_axis_tready = !i_q_full && (r_ang_cnt == 2'd0);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_lines_dec = r_lines - 16'd1;
    assign w_words_dec = r_words - 16'd1;
    assign w_bytes_inc = {1'b0, s_axis_tdata} + 17'd1;
    assign w_half      = w_bytes_inc[16:1];

    // start angle -> (angle / 10) mod 360, one multiply per cycle
    assign w_quot_prod = s_axis_tdata * RECIP_TEN;
    assign w_div_prod  = r_quot * RECIP_CIRCLE;
    assign w_rem       = r_quot - 13'({8'd0, r_div} * FULL_CIRCLE);

    assign w_byte0    = r_low_byte_first ? s_axis_tdata[7:0]  : s_axis_tdata[15:8];
    assign w_byte1    = r_low_byte_first ? s_axis_tdata[15:8] : s_axis_tdata[7:0];
    assign w_any_span = (s_axis_tdata[15:12] != 4'd0) || (s_axis_tdata[7:4] != 4'd0);

    always_comb begin
        n_state   = r_state;
        n_hpos    = r_hpos;
        n_lines   = r_lines;
        n_words   = r_words;
        n_cur     = r_cur;
        n_raster  = r_raster;
        n_started = r_started;
        n_ang_cnt = (r_ang_cnt != 2'd0) ? r_ang_cnt - 2'd1 : 2'd0;
        w_finish  = 1'b0;

        o_push.push             = 1'b0;
        o_push.entry.byte0      = w_byte0;
        o_push.entry.byte1      = w_byte1;
        o_push.entry.line_index = r_cur;
        o_push.entry.is_raster  = r_raster;
        o_push.entry.first      = !r_started;
        o_push.entry.done       = 1'b0;

        if (r_ang_cnt == 2'd1) begin
            n_cur = {3'd0, w_rem};
        end

        if (w_accept) begin
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tdata == CODE_RADIAL ||
                        s_axis_tdata == CODE_RASTER_A ||
                        s_axis_tdata == CODE_RASTER_B) begin
                        n_raster  = (s_axis_tdata != CODE_RADIAL);
                        n_state   = ST_HDR;
                        n_hpos    = 4'd1;
                        n_lines   = 16'd0;
                        n_cur     = 16'd0;
                        n_started = 1'b0;
                    end
                end
                ST_HDR: begin
                    if (r_hpos == (r_raster ? RASTER_COUNT_POS : RADIAL_COUNT_POS)) begin
                        n_lines = s_axis_tdata;
                    end
                    n_hpos = r_hpos + 4'd1;
                    if (n_hpos >= (r_raster ? RASTER_HDR_LEN : RADIAL_HDR_LEN)) begin
                        n_hpos  = 4'd0;
                        n_cur   = 16'd0;
                        n_state = (n_lines == 16'd0) ? ST_IDLE : ST_LHDR;
                    end
                end
                ST_LHDR: begin
                    n_started = 1'b0;
                    if (r_raster) begin
                        n_words = w_half;
                        if (w_half == 16'd0) begin
                            w_finish = 1'b1;
                        end else begin
                            n_state = ST_DATA;
                        end
                    end else begin
                        case (r_hpos)
                            4'd0: begin
                                n_words = s_axis_tdata;
                                n_hpos  = 4'd1;
                            end
                            4'd1: begin
                                n_ang_cnt = 2'd2;
                                n_hpos    = 4'd2;
                            end
                            default: begin
                                n_hpos = 4'd0;
                                if (r_words == 16'd0) begin
                                    w_finish = 1'b1;
                                end else begin
                                    n_state = ST_DATA;
                                end
                            end
                        endcase
                    end
                end
                ST_DATA: begin
                    o_push.push = w_any_span;
                    if (w_any_span) begin
                        n_started = 1'b1;
                    end
                    n_words = w_words_dec;
                    if (w_words_dec == 16'd0) begin
                        w_finish = 1'b1;
                        o_push.entry.done = (w_lines_dec == 16'd0);
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase

            if (w_finish) begin
                n_lines = w_lines_dec;
                if (r_raster) begin
                    n_cur = r_cur + 16'd1;
                end
                n_hpos  = 4'd0;
                n_state = (w_lines_dec == 16'd0) ? ST_IDLE : ST_LHDR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_hpos           <= 4'd0;
            r_lines          <= 16'd0;
            r_words          <= 16'd0;
            r_cur            <= 16'd0;
            r_raster         <= 1'b0;
            r_started        <= 1'b0;
            r_low_byte_first <= 1'b1;
            r_ang_cnt        <= 2'd0;
        end else begin
            r_state   <= n_state;
            r_hpos    <= n_hpos;
            r_lines   <= n_lines;
            r_words   <= n_words;
            r_cur     <= n_cur;
            r_raster  <= n_raster;
            r_started <= n_started;
            r_ang_cnt <= n_ang_cnt;
            if (i_cfg_we) begin
                r_low_byte_first <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && r_state == ST_LHDR && !r_raster && r_hpos == 4'd1) begin
            r_quot <= w_quot_prod[RECIP_TEN_SHIFT +: 13];
        end
        r_div <= w_div_prod[RECIP_CIRCLE_SHIFT +: 5];
    end

endmodule

// File: src/rlepd_queue.sv
// Small register queue between the parser and the run expander.
module rlepd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rlepd_pkg::t_push      i_push,
    output logic                  o_full,
    output logic                  o_valid,
    output rlepd_pkg::t_entry     o_entry,
    input  logic                  i_pop
);
    import rlepd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [AW:0]     r_count;
    logic            w_wr;
    logic            w_rd;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign w_wr    = i_push.push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

endmodule

// File: src/rlepd_back.sv
// Back end: expands each queued run halfword into colors, one per cycle while m_axis_tready does not hold the output.
module rlepd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  rlepd_pkg::t_entry     i_entry,
    output logic                  o_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // [3:0] color, [19:4] line_index, pad
    output logic [2:0]            m_axis_tuser,   // [0] is_raster, [1] line_start, [2] packet_done
    output logic                  m_axis_tlast
);
    import rlepd_pkg::*;

    logic         r_busy, n_busy;
    logic         r_sel, n_sel;
    logic [3:0]   r_cnt, n_cnt;
    logic         r_emitted, n_emitted;
    t_entry       r_ent;

    logic         r_ovalid;
    logic [3:0]   r_color;
    logic [15:0]  r_line;
    logic         r_oraster, r_ostart, r_odone, r_olast;

    logic         w_can_emit;
    logic         w_emit;
    logic         w_load;
    logic [3:0]   w_span1;
    logic         w_last;

    assign w_span1    = r_ent.byte1[7:4];
    assign w_can_emit = !r_ovalid || m_axis_tready;
    assign w_emit     = r_busy && (r_cnt != 4'd0) && w_can_emit;
    assign w_load     = !r_busy && i_q_valid;
    assign o_pop      = w_load;
    assign w_last     = (r_cnt == 4'd1) && (r_sel || w_span1 == 4'd0);

    always_comb begin
        n_busy    = r_busy;
        n_sel     = r_sel;
        n_cnt     = r_cnt;
        n_emitted = r_emitted;
        if (w_load) begin
            n_busy    = 1'b1;
            n_sel     = 1'b0;
            n_cnt     = i_entry.byte0[7:4];
            n_emitted = 1'b0;
        end else if (r_busy && r_cnt == 4'd0) begin
            // first byte had zero span
            if (r_sel) begin
                n_busy = 1'b0;
            end else begin
                n_sel = 1'b1;
                n_cnt = w_span1;
            end
        end else if (w_emit) begin
            n_emitted = 1'b1;
            if (r_cnt == 4'd1) begin
                if (!r_sel && w_span1 != 4'd0) begin
                    n_sel = 1'b1;
                    n_cnt = w_span1;
                end else begin
                    n_busy = 1'b0;
                    n_cnt  = 4'd0;
                end
            end else begin
                n_cnt = r_cnt - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_sel     <= 1'b0;
            r_cnt     <= 4'd0;
            r_emitted <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_sel     <= n_sel;
            r_cnt     <= n_cnt;
            r_emitted <= n_emitted;
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ent <= i_entry;
        end
        if (w_emit) begin
            r_color   <= r_sel ? r_ent.byte1[3:0] : r_ent.byte0[3:0];
            r_line    <= r_ent.line_index;
            r_oraster <= r_ent.is_raster;
            r_ostart  <= r_ent.first && !r_emitted;
            r_odone   <= r_ent.done;
            r_olast   <= w_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_line, r_color};
    assign m_axis_tuser  = {r_odone, r_ostart, r_oraster};
    assign m_axis_tlast  = r_olast;

endmodule

// File: src/radar_rle_packet_decoder.sv
// Top level of the radar run-length packet decoder.
// Usage:
//   s_axis carries packet halfwords (first file byte in bits 15..8), one request
//   per halfword. m_axis carries expanded colors; tlast marks the final color
//   produced by one input halfword, tuser holds is_raster, line_start and
//   packet_done. i_cfg_we/i_cfg_wdata write low_byte_first while idle.
// Flow:
//   After the radial start angle is accepted, s_axis_tready is held low while
//   (angle/10) mod 360 is worked out by multiplies through r_quot and r_div.
//   A run halfword passes from the parser into the queue; the expander then
//   loads it, emits its colors in turn and takes an extra step when the first
//   expanded byte has a zero span. It loads the next halfword only once it is
//   done with the last, so the expander sets the throughput. With the expander
//   idle, the queue, the expander's entry register and the output register
//   lie between an accepted halfword and its first color.
//   Halfwords that produce no color are dropped by the parser.
// Reset: synchronous, active low; parser returns to idle, queue empties,
//   low_byte_first goes to 1.
// Stall: the output register holds while m_axis_tready is low; the queue
//   fills, then s_axis_tready drops.
module radar_rle_packet_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // [15:0] word
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata,   // [3:0] color, [19:4] line_index, pad
    output logic [2:0]   m_axis_tuser,   // [0] is_raster, [1] line_start, [2] packet_done
    output logic         m_axis_tlast
);
    import rlepd_pkg::*;

    t_push   w_push;
    t_entry  w_q_entry;
    logic    w_q_full;
    logic    w_q_valid;
    logic    w_pop;

    rlepd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_q_full      (w_q_full),
        .o_push        (w_push)
    );

    rlepd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry),
        .i_pop   (w_pop)
    );

    rlepd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_entry       (w_q_entry),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push.push && w_q_full))
        else $error("run halfword pushed into a full queue");

    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push |-> (s_axis_tvalid && s_axis_tready))
        else $error("queue push without an accepted halfword");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from an empty queue");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push |=> w_q_valid)
        else $error("queue empty right after a push");
`endif

endmodule
